// ===== hw/rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Request and status codes, cell operations and the cell control struct.
// No dependencies.
package deq_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SIZE       = 3'd4,
    REQ_EMPTY      = 3'd5,
    REQ_PEEK_FRONT = 3'd6,
    REQ_PEEK_BACK  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_RIGHT,
    CELL_SHIFT_LEFT,
    CELL_PUSH_BACK,
    CELL_POP_BACK
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [WordW-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/double_ended_queue_core.sv =====
// Double-ended queue of 32-bit words held in a chain of DEPTH cells, front at cell 0.
// Push, pop/peek front, size, empty: one word per cycle unless the response stalls;
// response registered for the next cycle; a push answers only when the queue is full.
// Pop/peek back wait for the back word to ripple one cell per cycle to the front.
// Reset (rst_ni low, asynchronous) empties the queue; stored words keep no reset value.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic [2:0]                        req_type_i,
  input  logic signed [deq_pkg::WordW-1:0]  push_value_i,
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output logic signed [deq_pkg::WordW-1:0]  data_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_WAIT_BACK
  } state_e;

  state_e                    state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [CntW-1:0]           wait_q, wait_d;
  logic                      back_pop_q, back_pop_d;
  logic                      rsp_valid_q, rsp_valid_d;
  logic [deq_pkg::WordW-1:0] rsp_data_q, rsp_data_d;
  deq_pkg::status_e          rsp_status_q, rsp_status_d;

  deq_pkg::cell_ctrl_t       ctrl;
  logic [deq_pkg::WordW-1:0] cell_data [DEPTH];
  logic [deq_pkg::WordW-1:0] cell_back [DEPTH];
  logic [DEPTH-1:0]          cell_valid;

  logic out_free;
  logic accept;
  logic is_empty;
  logic is_full;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && out_free;
  assign accept      = req_valid_i && req_ready_o;
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CntW'(DEPTH));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    wait_d       = wait_q;
    back_pop_d   = back_pop_q;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    rsp_data_d   = rsp_data_q;
    rsp_status_d = rsp_status_q;
    ctrl.op      = deq_pkg::CELL_HOLD;
    ctrl.value   = push_value_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (deq_pkg::req_e'(req_type_i)) inside
            deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
              if (is_full) begin
                rsp_valid_d  = 1'b1;
                rsp_data_d   = '0;
                rsp_status_d = deq_pkg::STAT_FULL;
              end else begin
                ctrl.op = (deq_pkg::req_e'(req_type_i) == deq_pkg::REQ_PUSH_FRONT)
                          ? deq_pkg::CELL_SHIFT_RIGHT : deq_pkg::CELL_PUSH_BACK;
                count_d = count_q + CntW'(1);
              end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
              rsp_valid_d = 1'b1;
              if (is_empty) begin
                rsp_data_d   = '1;
                rsp_status_d = deq_pkg::STAT_EMPTY;
              end else begin
                rsp_data_d   = cell_data[0];
                rsp_status_d = deq_pkg::STAT_OK;
                if (deq_pkg::req_e'(req_type_i) == deq_pkg::REQ_POP_FRONT) begin
                  ctrl.op = deq_pkg::CELL_SHIFT_LEFT;
                  count_d = count_q - CntW'(1);
                end
              end
            end
            deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
              if (is_empty) begin
                rsp_valid_d  = 1'b1;
                rsp_data_d   = '1;
                rsp_status_d = deq_pkg::STAT_EMPTY;
              end else begin
                // Wait in S_WAIT_BACK until the back word reaches cell 0 of the wave.
                state_d    = S_WAIT_BACK;
                wait_d     = count_q;
                back_pop_d = (deq_pkg::req_e'(req_type_i) == deq_pkg::REQ_POP_BACK);
              end
            end
            deq_pkg::REQ_SIZE: begin
              rsp_valid_d  = 1'b1;
              rsp_data_d   = deq_pkg::WordW'(count_q);
              rsp_status_d = deq_pkg::STAT_OK;
            end
            deq_pkg::REQ_EMPTY: begin
              rsp_valid_d  = 1'b1;
              rsp_data_d   = deq_pkg::WordW'(is_empty);
              rsp_status_d = deq_pkg::STAT_OK;
            end
          endcase
        end
      end
      S_WAIT_BACK: begin
        if (wait_q != '0) begin
          wait_d = wait_q - CntW'(1);
        end else if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_data_d   = cell_back[0];
          rsp_status_d = deq_pkg::STAT_OK;
          state_d      = S_IDLE;
          if (back_pop_q) begin
            ctrl.op = deq_pkg::CELL_POP_BACK;
            count_d = count_q - CntW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      wait_q       <= '0;
      back_pop_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_data_q   <= '0;
      rsp_status_q <= deq_pkg::STAT_OK;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      wait_q       <= wait_d;
      back_pop_q   <= back_pop_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_data_q   <= rsp_data_d;
      rsp_status_q <= rsp_status_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [deq_pkg::WordW-1:0] left_data, right_data, right_back;
    logic                      left_valid, right_valid;

    if (i == 0) begin : g_head
      assign left_data  = ctrl.value;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
      assign right_back  = '0;
    end else begin : g_inner
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
      assign right_back  = cell_back[i+1];
    end

    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .right_back_i  (right_back),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .back_o        (cell_back[i])
    );
  end

  assign rsp_valid_o = rsp_valid_q;
  assign data_o      = rsp_data_q;
  assign status_o    = rsp_status_q;

  // The word count and the occupied flags at both ends of the chain agree.
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !cell_valid[0])
    else $error("count and front cell occupancy disagree");

  a_full_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(DEPTH)) == cell_valid[DEPTH-1])
    else $error("count and last cell occupancy disagree");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("count exceeds depth");

  a_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (status_o == deq_pkg::STAT_EMPTY) |-> (data_o == '1))
    else $error("empty status without all-ones data");

  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT_BACK) && (wait_q != '0) |=> $stable(count_q))
    else $error("queue changed while back word was in flight");

endmodule

// ===== hw/rtl/deq_cell.sv =====
// One storage cell of the queue chain: a word, its occupied flag and one
// stage of the back-word wave that travels toward the front.
// Depends on deq_pkg.
module deq_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  deq_pkg::cell_ctrl_t            ctrl_i,
  input  logic [deq_pkg::WordW-1:0]      left_data_i,
  input  logic                           left_valid_i,
  input  logic [deq_pkg::WordW-1:0]      right_data_i,
  input  logic                           right_valid_i,
  input  logic [deq_pkg::WordW-1:0]      right_back_i,
  output logic [deq_pkg::WordW-1:0]      data_o,
  output logic                           valid_o,
  output logic [deq_pkg::WordW-1:0]      back_o
);

  logic [deq_pkg::WordW-1:0] data_q, data_d;
  logic [deq_pkg::WordW-1:0] back_q, back_d;
  logic                      valid_q, valid_d;
  logic                      is_last;

  // The last occupied cell is the one whose right neighbor is empty.
  assign is_last = valid_q && !right_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      deq_pkg::CELL_SHIFT_RIGHT: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      deq_pkg::CELL_SHIFT_LEFT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      deq_pkg::CELL_PUSH_BACK: begin
        if (!valid_q && left_valid_i) begin
          data_d  = ctrl_i.value;
          valid_d = 1'b1;
        end
      end
      deq_pkg::CELL_POP_BACK: begin
        if (is_last) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
    back_d = is_last ? data_q : right_back_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    back_q <= back_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign back_o  = back_q;

endmodule
